[rtl/ktmp_pkg.sv]
package ktmp_pkg;

  localparam int K_MAX      = 16;
  localparam int PRICE_BITS = 16;
  localparam int PROFIT_W   = 20;
  localparam int HOLD_W     = PROFIT_W + 1;
  localparam int CFG_W      = 5;
  localparam int ARITH_W    = HOLD_W + 1;

  localparam int IDX_W = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CNT_W = $clog2(K_MAX + 1);
  localparam int CMP_W = (CFG_W > CNT_W) ? CFG_W : CNT_W;

  localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(2);
  localparam logic [HOLD_W-1:0] HOLD_RESET = {1'b1, {(HOLD_W-1){1'b0}}};

  localparam int PC_W = 2;
  localparam logic [PC_W-1:0] STEP_TAKE = 2'd0;
  localparam logic [PC_W-1:0] STEP_LOOP = 2'd1;
  localparam logic [PC_W-1:0] STEP_TEST = 2'd2;
  localparam logic [PC_W-1:0] STEP_EMIT = 2'd3;

  localparam logic [1:0] COND_NO_INPUT = 2'd0;
  localparam logic [1:0] COND_MORE     = 2'd1;
  localparam logic [1:0] COND_NOT_LAST = 2'd2;
  localparam logic [1:0] COND_OUT_BUSY = 2'd3;

  typedef struct packed {
    logic            accept;
    logic            upd;
    logic            sel_in;
    logic            emit;
    logic [1:0]      cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t w;
    w = '0;
    unique case (pc)
      STEP_TAKE: begin
        w.accept = 1'b1;
        w.upd    = 1'b1;
        w.sel_in = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_TAKE;
      end
      STEP_LOOP: begin
        w.upd    = 1'b1;
        w.cond   = COND_MORE;
        w.target = STEP_LOOP;
      end
      STEP_TEST: begin
        w.cond   = COND_NOT_LAST;
        w.target = STEP_TAKE;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

[rtl/ktmp_ifs.sv]
interface ktmp_in_if;
  logic                            valid;
  logic                            ready;
  logic [ktmp_pkg::PRICE_BITS-1:0] price;
  logic                            last_day;
  modport source (output valid, price, last_day, input ready);
  modport sink   (input valid, price, last_day, output ready);
endinterface

interface ktmp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ktmp_pkg::PROFIT_W-1:0] best_profit;
  modport source (output valid, best_profit, input ready);
  modport sink   (input valid, best_profit, output ready);
endinterface

interface ktmp_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ktmp_pkg::CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[rtl/k_transaction_max_profit.sv]
// k-transaction stock profit engine
// in_word: one price word per day with a last_day flag; valid/ready handshake.
// out_word: one best_profit word after each word marked last_day.
// cfg_word: writes max_transactions (0..31, saturated to the table depth);
//   write only while the block is idle.
// a small microcode table sequences the work: a take step accepts the price and
//   updates transaction count 1, then a loop step updates each further count
//   in turn through a single add/compare datapath, then one decision step.
// the next price word is accepted only after the per-count update loop and the
//   decision step have run; a last_day word adds one emit step.
// the result for a last_day word is registered by that emit step.
// results sit in an output register; the next price is accepted while a
//   result waits, but a further result stalls the emit step until out_word
//   takes the pending one.
// reset (rst_n low, synchronous): all per-count state cleared, limit set
//   to 2, no result pending; state also clears after every last_day word.
module k_transaction_max_profit (
  input  logic           clk,
  input  logic           rst_n,
  ktmp_in_if.sink        in_word,
  ktmp_out_if.source     out_word,
  ktmp_cfg_if.sink       cfg_word
);

  logic [ktmp_pkg::PC_W-1:0]       pc_r, pc_nxt;
  logic [ktmp_pkg::CNT_W-1:0]      t_r, t_nxt;
  logic [ktmp_pkg::PRICE_BITS-1:0] price_r;
  logic                            last_r;
  logic [ktmp_pkg::PROFIT_W-1:0]   prev_r;
  logic [ktmp_pkg::PROFIT_W-1:0]   ans_r;
  logic [ktmp_pkg::PROFIT_W-1:0]   out_r;
  logic                            out_v_r;
  logic [ktmp_pkg::CFG_W-1:0]      kcfg_r;
  logic [ktmp_pkg::K_MAX-1:0]      vld_r;
  logic [ktmp_pkg::HOLD_W-1:0]     hold_r [ktmp_pkg::K_MAX];
  logic [ktmp_pkg::PROFIT_W-1:0]   idle_r [ktmp_pkg::K_MAX];

  ktmp_pkg::ctrl_t                 cw;
  logic                            take, upd, emit, busy, jump;
  logic [ktmp_pkg::CNT_W-1:0]      cur_t;
  logic [ktmp_pkg::IDX_W-1:0]      idx;
  logic [ktmp_pkg::PRICE_BITS-1:0] p;
  logic [ktmp_pkg::PROFIT_W-1:0]   prev;
  logic [ktmp_pkg::HOLD_W-1:0]     hold_rd;
  logic [ktmp_pkg::PROFIT_W-1:0]   idle_rd;
  logic signed [ktmp_pkg::ARITH_W-1:0] buy, hold_x, hold_new, sell;
  logic [ktmp_pkg::PROFIT_W-1:0]   idle_new;
  logic [ktmp_pkg::CMP_W-1:0]      k_ext, k_sat, cur_ext;

  assign cw   = ktmp_pkg::ucode(pc_r);
  assign busy = out_v_r & ~out_word.ready;
  assign take = cw.accept & in_word.valid;
  assign emit = cw.emit & ~busy;
  assign upd  = cw.sel_in ? take
              : (cw.upd & (t_r < ktmp_pkg::CNT_W'(ktmp_pkg::K_MAX)));

  assign cur_t = cw.sel_in ? '0 : t_r;
  assign idx   = cur_t[ktmp_pkg::IDX_W-1:0];
  assign p     = cw.sel_in ? in_word.price : price_r;
  assign prev  = cw.sel_in ? '0 : prev_r;

  assign hold_rd = vld_r[idx] ? hold_r[idx] : ktmp_pkg::HOLD_RESET;
  assign idle_rd = vld_r[idx] ? idle_r[idx] : '0;

  always_comb begin
    buy      = $signed(ktmp_pkg::ARITH_W'(prev)) - $signed(ktmp_pkg::ARITH_W'(p));
    hold_x   = ktmp_pkg::ARITH_W'($signed(hold_rd));
    hold_new = (buy > hold_x) ? buy : hold_x;
    sell     = hold_new + $signed(ktmp_pkg::ARITH_W'(p));
    idle_new = (sell > $signed(ktmp_pkg::ARITH_W'(idle_rd)))
             ? sell[ktmp_pkg::PROFIT_W-1:0] : idle_rd;
  end

  assign k_ext   = ktmp_pkg::CMP_W'(kcfg_r);
  assign k_sat   = (k_ext > ktmp_pkg::CMP_W'(ktmp_pkg::K_MAX))
                 ? ktmp_pkg::CMP_W'(ktmp_pkg::K_MAX) : k_ext;
  assign cur_ext = ktmp_pkg::CMP_W'(cur_t);

  always_comb begin
    unique case (cw.cond)
      ktmp_pkg::COND_NO_INPUT: jump = ~in_word.valid;
      ktmp_pkg::COND_MORE:     jump = t_r < ktmp_pkg::CNT_W'(ktmp_pkg::K_MAX - 1);
      ktmp_pkg::COND_NOT_LAST: jump = ~last_r;
      ktmp_pkg::COND_OUT_BUSY: jump = busy;
      default:                 jump = 1'b0;
    endcase
    pc_nxt = jump ? cw.target : pc_r + ktmp_pkg::PC_W'(1);
    t_nxt  = upd ? cur_t + ktmp_pkg::CNT_W'(1) : t_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r    <= ktmp_pkg::STEP_TAKE;
      t_r     <= '0;
      out_v_r <= 1'b0;
      kcfg_r  <= ktmp_pkg::CFG_RESET;
      vld_r   <= '0;
    end else begin
      pc_r <= pc_nxt;
      t_r  <= t_nxt;
      if (cfg_word.valid) begin
        kcfg_r <= cfg_word.data;
      end
      if (emit) begin
        out_v_r <= 1'b1;
        vld_r   <= '0;
      end else begin
        if (out_word.ready) begin
          out_v_r <= 1'b0;
        end
        if (upd) begin
          vld_r[idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      price_r <= in_word.price;
      last_r  <= in_word.last_day;
    end
    if (upd) begin
      hold_r[idx] <= hold_new[ktmp_pkg::HOLD_W-1:0];
      idle_r[idx] <= idle_new;
      prev_r      <= idle_new;
      if (cur_ext == k_sat - ktmp_pkg::CMP_W'(1)) begin
        ans_r <= idle_new;
      end
    end
    if (emit) begin
      out_r <= (k_sat == '0) ? '0 : ans_r;
    end
  end

  assign in_word.ready        = cw.accept;
  assign cfg_word.ready       = 1'b1;
  assign out_word.valid       = out_v_r;
  assign out_word.best_profit = out_r;

endmodule

[rtl/ktmp_checker.sv]
module ktmp_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          in_last_day,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [ktmp_pkg::PROFIT_W-1:0] out_best_profit
);

  logic in_acc;
  assign in_acc = in_valid & in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_best_profit))
    else $error("result word changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input ready right after a word was taken");

  a_busy_loop: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ##(ktmp_pkg::K_MAX - 1) !in_ready)
    else $error("input ready before the update loop finished");

  a_ready_again: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_last_day |-> ##(ktmp_pkg::K_MAX + 1) in_ready)
    else $error("input not ready after a non-final word");

endmodule

bind k_transaction_max_profit ktmp_checker u_ktmp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_word.valid),
  .in_ready        (in_word.ready),
  .in_last_day     (in_word.last_day),
  .out_valid       (out_word.valid),
  .out_ready       (out_word.ready),
  .out_best_profit (out_word.best_profit)
);

[tb/sv/tb.sv]
module tb;
  import ktmp_pkg::*;

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic                  last_day;
  } day_t;

  typedef enum {STYLE_ANY, STYLE_NEAR, STYLE_RAILS, STYLE_SEESAW, STYLE_RAMP} price_style_e;
  typedef enum {SND_STEADY, SND_BURSTY} sender_mode_e;
  typedef enum {RCV_OPEN, RCV_RANDOM, RCV_PATTERN} receiver_mode_e;

  localparam int SETTLE_CYCLES = K_MAX + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_DAYS = 500;

  logic clk;
  logic rst_n;

  ktmp_in_if  in_word();
  ktmp_out_if out_word();
  ktmp_cfg_if cfg_word();

  k_transaction_max_profit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word),
    .cfg_word (cfg_word)
  );

  // predicted ledger
  logic signed [HOLD_W-1:0] hold_best [K_MAX];
  logic [PROFIT_W-1:0]      free_best [K_MAX];
  logic [CFG_W-1:0]         trade_limit;
  logic [PROFIT_W-1:0]      profit_q [$];

  day_t day_q [$];
  day_t next_day;
  int   days_sent;
  int   fail_count;
  int   quiet_cycles;
  bit   in_taken;
  int   burst_left;
  int   gap_left;
  int   rcv_tick;
  int   rcv_period;
  int   rcv_stall;
  int   run_base;
  logic [PROFIT_W-1:0] want;

  sender_mode_e   snd_mode;
  receiver_mode_e rcv_mode;

  function automatic void clear_ledger();
    for (int t = 0; t < K_MAX; t++) begin
      hold_best[t] = HOLD_RESET;
      free_best[t] = '0;
    end
  endfunction

  task automatic settle_day(input logic [PRICE_BITS-1:0] price, input logic last);
    longint p;
    longint prev_free;
    longint buy;
    longint sell;
    int     k;
    p = longint'(price);
    prev_free = 0;
    for (int t = 0; t < K_MAX; t++) begin
      buy = prev_free - p;
      if (buy > longint'(hold_best[t])) hold_best[t] = buy[HOLD_W-1:0];
      sell = longint'(hold_best[t]) + p;
      if (sell > longint'(free_best[t])) free_best[t] = sell[PROFIT_W-1:0];
      prev_free = longint'(free_best[t]);
    end
    if (last) begin
      k = (int'(trade_limit) > K_MAX) ? K_MAX : int'(trade_limit);
      profit_q.push_back((k == 0) ? '0 : free_best[k-1]);
      clear_ledger();
    end
  endtask

  task automatic push_day(input logic [PRICE_BITS-1:0] price, input logic last);
    day_t d;
    d.price = price;
    d.last_day = last;
    day_q.push_back(d);
    days_sent++;
  endtask

  function automatic logic [PRICE_BITS-1:0] pick_price(input price_style_e style, input int idx);
    logic [PRICE_BITS-1:0] p;
    case (style)
      STYLE_NEAR:   p = PRICE_BITS'((run_base & 16'hFF00) | $urandom_range(0, 255));
      STYLE_RAILS:  p = ($urandom_range(0, 1) != 0) ? '1 : '0;
      STYLE_SEESAW: p = (idx % 2 != 0) ? '1 : '0;
      STYLE_RAMP:   p = PRICE_BITS'(run_base + idx * 997);
      default:      p = PRICE_BITS'($urandom_range(0, 65535));
    endcase
    return p;
  endfunction

  task automatic queue_run(input int len, input price_style_e style, input bit close);
    run_base = $urandom_range(0, 65535);
    for (int i = 0; i < len; i++)
      push_day(pick_price(style, i), close && (i == len - 1));
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_word.valid = 1'b1;
    cfg_word.data  = value;
    do @(posedge clk); while (!cfg_word.ready);
    @(negedge clk);
    cfg_word.valid = 1'b0;
  endtask

  task automatic drain();
    while (day_q.size() != 0 || in_word.valid || profit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // word sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_word.valid    <= 1'b0;
      in_word.price    <= '0;
      in_word.last_day <= 1'b0;
    end else if (!in_word.valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_word.valid <= 1'b0;
      end else if (day_q.size() != 0) begin
        next_day = day_q.pop_front();
        in_word.valid    <= 1'b1;
        in_word.price    <= next_day.price;
        in_word.last_day <= next_day.last_day;
        if (snd_mode == SND_BURSTY) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 6);
            gap_left   = $urandom_range(1, 30);
          end
        end
      end else begin
        in_word.valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    rcv_tick++;
    case (rcv_mode)
      RCV_OPEN:   out_word.ready <= 1'b1;
      RCV_RANDOM: out_word.ready <= ($urandom_range(0, 2) != 0);
      default:    out_word.ready <= ((rcv_tick % rcv_period) >= rcv_stall);
    endcase
  end

  // monitor and checker
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n) begin
      quiet_cycles++;
      if (cfg_word.valid && cfg_word.ready) begin
        trade_limit = cfg_word.data;
        quiet_cycles = 0;
      end
      if (out_word.valid && out_word.ready) begin
        quiet_cycles = 0;
        if (profit_q.size() == 0) begin
          $error("best_profit %0d arrived with nothing expected", out_word.best_profit);
          fail_count++;
        end else begin
          want = profit_q.pop_front();
          if (out_word.best_profit !== want) begin
            $error("best_profit mismatch: expected %0d, got %0d", want, out_word.best_profit);
            fail_count++;
          end
        end
      end
      if (in_word.valid && in_word.ready) begin
        in_taken = 1'b1;
        quiet_cycles = 0;
        settle_day(in_word.price, in_word.last_day);
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_word.valid    = 1'b0;
    in_word.price    = '0;
    in_word.last_day = 1'b0;
    out_word.ready   = 1'b0;
    cfg_word.valid   = 1'b0;
    cfg_word.data    = '0;
    days_sent    = 0;
    fail_count   = 0;
    quiet_cycles = 0;
    burst_left   = 0;
    gap_left     = 0;
    rcv_tick     = 0;
    rcv_period   = 8;
    rcv_stall    = 2;
    run_base     = 0;
    snd_mode     = SND_STEADY;
    rcv_mode     = RCV_OPEN;
    trade_limit  = CFG_RESET;
    clear_ledger();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default limit, single day and extreme prices
    push_day('1, 1'b1);
    push_day('0, 1'b0);
    push_day('1, 1'b1);
    push_day('1, 1'b0);
    push_day('0, 1'b1);
    drain();

    // zero limit
    write_limit(CFG_W'(0));
    push_day(16'd10, 1'b0);
    push_day(16'd50, 1'b1);
    drain();

    // limit above table depth saturates
    write_limit('1);
    queue_run(12, STYLE_SEESAW, 1'b1);
    drain();

    // limit changed while a sequence is open
    push_day(16'd100, 1'b0);
    push_day(16'd200, 1'b0);
    push_day(16'd50, 1'b0);
    drain();
    write_limit(CFG_W'(1));
    push_day(16'd300, 1'b1);
    drain();

    // full table at the largest profit
    write_limit(CFG_W'(K_MAX));
    rcv_mode = RCV_RANDOM;
    queue_run(2 * K_MAX, STYLE_SEESAW, 1'b1);
    drain();

    while (days_sent < RANDOM_DAYS + 25) begin
      case ($urandom_range(0, 5))
        0:       write_limit(CFG_W'(0));
        1:       write_limit(CFG_W'(1));
        2:       write_limit(CFG_W'(2));
        3:       write_limit(CFG_W'(K_MAX));
        4:       write_limit('1);
        default: write_limit(CFG_W'($urandom_range(0, 31)));
      endcase
      snd_mode   = ($urandom_range(0, 2) == 0) ? SND_STEADY : SND_BURSTY;
      rcv_mode   = receiver_mode_e'($urandom_range(0, 2));
      rcv_period = $urandom_range(4, 60);
      rcv_stall  = $urandom_range(1, rcv_period - 1);
      for (int s = 0, n = $urandom_range(1, 4); s < n; s++) begin
        queue_run(($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12),
                  price_style_e'($urandom_range(0, 4)),
                  (s < n - 1) || ($urandom_range(0, 4) != 0));
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
